FILE: rtl/obb_sat_pkg.sv
// shared types, constants and step decode for the oriented box overlap test
package obb_sat_pkg;

    localparam int ADDR_W   = 6;
    localparam int RF_DEPTH = 45;

    // operand store layout
    localparam logic [ADDR_W-1:0] ADR_AXA = 6'd0;
    localparam logic [ADDR_W-1:0] ADR_AXB = 6'd9;
    localparam logic [ADDR_W-1:0] ADR_CA  = 6'd18;
    localparam logic [ADDR_W-1:0] ADR_CB  = 6'd21;
    localparam logic [ADDR_W-1:0] ADR_HA  = 6'd24;
    localparam logic [ADDR_W-1:0] ADR_HB  = 6'd27;
    localparam logic [ADDR_W-1:0] ADR_R   = 6'd30;
    localparam logic [ADDR_W-1:0] ADR_T   = 6'd39;
    localparam logic [ADDR_W-1:0] ADR_D   = 6'd42;

    // request op codes
    localparam logic [3:0] OP_HB  = 4'd9;
    localparam logic [3:0] OP_RUN = 4'd10;

    // axis codes
    localparam logic [3:0] AXIS_NONE = 4'd0;
    localparam logic [3:0] AXIS_A0   = 4'd1;
    localparam logic [3:0] AXIS_B0   = 4'd4;
    localparam logic [3:0] AXIS_X0   = 4'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_READ,
        ST_MUL,
        ST_WAIT,
        ST_END,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        PH_D,
        PH_R,
        PH_T,
        PH_A,
        PH_B,
        PH_X
    } t_phase;

    typedef struct packed {
        logic [ADDR_W-1:0] a_addr;
        logic [ADDR_W-1:0] b_addr;
        logic              b_abs;
        logic              pass;
        logic              to_rad;
        logic              neg;
        logic              last;
        logic              is_test;
        logic [ADDR_W-1:0] dst;
        logic [3:0]        axis;
    } t_step;

    function automatic logic [1:0] div3(input logic [3:0] g);
        logic [1:0] r;
        case (g)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            4'd6, 4'd7, 4'd8: r = 2'd2;
            default:          r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] mod3(input logic [3:0] g);
        logic [1:0] r;
        case (g)
            4'd0, 4'd3, 4'd6: r = 2'd0;
            4'd1, 4'd4, 4'd7: r = 2'd1;
            4'd2, 4'd5, 4'd8: r = 2'd2;
            default:          r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] inc3(input logic [1:0] v);
        logic [1:0] r;
        case (v)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // row-major index of a 3x3 entry
    function automatic logic [ADDR_W-1:0] ix3(input logic [1:0] r, input logic [1:0] c);
        return ADDR_W'(r) + ADDR_W'(r) + ADDR_W'(r) + ADDR_W'(c);
    endfunction

    function automatic logic [3:0] last_grp(input t_phase ph);
        logic [3:0] r;
        case (ph)
            PH_R, PH_X: r = 4'd8;
            default:    r = 4'd2;
        endcase
        return r;
    endfunction

    function automatic t_phase next_phase(input t_phase ph);
        t_phase r;
        case (ph)
            PH_D:    r = PH_R;
            PH_R:    r = PH_T;
            PH_T:    r = PH_A;
            PH_A:    r = PH_B;
            PH_B:    r = PH_X;
            default: r = PH_X;
        endcase
        return r;
    endfunction

    // one product term of the run program
    function automatic t_step step_decode(input t_phase ph, input logic [3:0] g,
                                          input logic [2:0] t);
        t_step      s;
        logic [1:0] i;
        logic [1:0] j;
        logic [1:0] i1;
        logic [1:0] i2;
        logic [1:0] j1;
        logic [1:0] j2;
        logic [1:0] gl;
        logic [2:0] tm2;
        logic [2:0] tm3;
        s   = '0;
        i   = div3(g);
        j   = mod3(g);
        i1  = inc3(i);
        i2  = inc3(i1);
        j1  = inc3(j);
        j2  = inc3(j1);
        gl  = g[1:0];
        tm2 = t - 3'd2;
        tm3 = t - 3'd3;
        case (ph)
            PH_D: begin
                s.pass = 1'b1;
                if (t == 3'd0) begin
                    s.a_addr = ADR_CB + ADDR_W'(g);
                end else begin
                    s.a_addr = ADR_CA + ADDR_W'(g);
                    s.neg    = 1'b1;
                    s.last   = 1'b1;
                end
                s.dst = ADR_D + ADDR_W'(g);
            end
            PH_R: begin
                s.a_addr = ADR_AXA + ix3(i, t[1:0]);
                s.b_addr = ADR_AXB + ix3(j, t[1:0]);
                s.last   = (t == 3'd2);
                s.dst    = ADR_R + ADDR_W'(g);
            end
            PH_T: begin
                s.a_addr = ADR_D + ADDR_W'(t[1:0]);
                s.b_addr = ADR_AXA + ix3(gl, t[1:0]);
                s.last   = (t == 3'd2);
                s.dst    = ADR_T + ADDR_W'(g);
            end
            PH_A: begin
                s.is_test = 1'b1;
                s.axis    = AXIS_A0 + 4'(gl);
                if (t == 3'd0) begin
                    s.a_addr = ADR_T + ADDR_W'(gl);
                    s.pass   = 1'b1;
                end else if (t == 3'd1) begin
                    s.a_addr = ADR_HA + ADDR_W'(gl);
                    s.pass   = 1'b1;
                    s.to_rad = 1'b1;
                end else begin
                    s.a_addr = ADR_HB + ADDR_W'(tm2[1:0]);
                    s.b_addr = ADR_R + ix3(gl, tm2[1:0]);
                    s.b_abs  = 1'b1;
                    s.to_rad = 1'b1;
                    s.last   = (t == 3'd4);
                end
            end
            PH_B: begin
                s.is_test = 1'b1;
                s.axis    = AXIS_B0 + 4'(gl);
                if (t < 3'd3) begin
                    s.a_addr = ADR_HA + ADDR_W'(t[1:0]);
                    s.b_addr = ADR_R + ix3(t[1:0], gl);
                    s.b_abs  = 1'b1;
                    s.to_rad = 1'b1;
                end else if (t < 3'd6) begin
                    s.a_addr = ADR_T + ADDR_W'(tm3[1:0]);
                    s.b_addr = ADR_R + ix3(tm3[1:0], gl);
                end else begin
                    s.a_addr = ADR_HB + ADDR_W'(gl);
                    s.pass   = 1'b1;
                    s.to_rad = 1'b1;
                    s.last   = 1'b1;
                end
            end
            PH_X: begin
                s.is_test = 1'b1;
                s.axis    = AXIS_X0 + g;
                case (t)
                    3'd0: begin
                        s.a_addr = ADR_HA + ADDR_W'(i1);
                        s.b_addr = ADR_R + ix3(i2, j);
                        s.b_abs  = 1'b1;
                        s.to_rad = 1'b1;
                    end
                    3'd1: begin
                        s.a_addr = ADR_HA + ADDR_W'(i2);
                        s.b_addr = ADR_R + ix3(i1, j);
                        s.b_abs  = 1'b1;
                        s.to_rad = 1'b1;
                    end
                    3'd2: begin
                        s.a_addr = ADR_HB + ADDR_W'(j1);
                        s.b_addr = ADR_R + ix3(i, j2);
                        s.b_abs  = 1'b1;
                        s.to_rad = 1'b1;
                    end
                    3'd3: begin
                        s.a_addr = ADR_HB + ADDR_W'(j2);
                        s.b_addr = ADR_R + ix3(i, j1);
                        s.b_abs  = 1'b1;
                        s.to_rad = 1'b1;
                    end
                    3'd4: begin
                        s.a_addr = ADR_T + ADDR_W'(i2);
                        s.b_addr = ADR_R + ix3(i1, j);
                    end
                    default: begin
                        s.a_addr = ADR_T + ADDR_W'(i1);
                        s.b_addr = ADR_R + ix3(i2, j);
                        s.neg    = 1'b1;
                        s.last   = 1'b1;
                    end
                endcase
            end
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

FILE: rtl/obb_sat_mem.sv
// operand store: one write port, two registered read ports
module obb_sat_mem #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [obb_sat_pkg::ADDR_W-1:0]     i_waddr,
    input  logic [DATA_WIDTH-1:0]              i_wdata,
    input  logic [obb_sat_pkg::ADDR_W-1:0]     i_raddr_a,
    input  logic [obb_sat_pkg::ADDR_W-1:0]     i_raddr_b,
    output logic [DATA_WIDTH-1:0]              o_rdata_a,
    output logic [DATA_WIDTH-1:0]              o_rdata_b
);
    import obb_sat_pkg::*;

    logic [DATA_WIDTH-1:0] r_mem [RF_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

FILE: rtl/obb_sat_mul.sv
// shared fixed-point multiplier: truncating magnitude product, saturated
module obb_sat_mul #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_pass,
    input  logic signed [DATA_WIDTH-1:0] i_a,
    input  logic signed [DATA_WIDTH-1:0] i_b,
    output logic                         o_done,
    output logic signed [DATA_WIDTH-1:0] o_res
);
    localparam int DW = DATA_WIDTH;
    localparam int HB = (DW + 1) / 2;
    localparam int HI = DW - HB;
    localparam int W2 = 2 * DW;

    logic [3:0]             r_vld;
    logic [DW-1:0]          r_ua;
    logic [DW-1:0]          r_ub;
    logic                   r_neg;
    logic                   r_pass;
    logic signed [DW-1:0]   r_a;
    logic [DW+HB-1:0]       r_plo;
    logic [W2-1:0]          r_prod;
    logic signed [DW-1:0]   r_res;

    logic [DW+HB-1:0]       plo;
    logic [DW+HI-1:0]       phi;
    logic [W2-1:0]          q;
    logic                   over;
    logic signed [DW-1:0]   sat_res;

    assign plo = r_ua * r_ub[HB-1:0];
    assign phi = r_ua * r_ub[DW-1:HB];
    assign q    = r_prod >> FRAC_BITS;
    assign over = |q[W2-1:DW-1];

    always_comb begin
        if (over) begin
            sat_res = r_neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            sat_res = r_neg ? -$signed(q[DW-1:0]) : $signed(q[DW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ua   <= i_a[DW-1] ? DW'(-i_a) : DW'(i_a);
            r_ub   <= i_b[DW-1] ? DW'(-i_b) : DW'(i_b);
            r_neg  <= i_a[DW-1] ^ i_b[DW-1];
            r_pass <= i_pass;
            r_a    <= i_a;
        end
        r_plo  <= plo;
        r_prod <= W2'(r_plo) + (W2'(phi) << HB);
        r_res  <= r_pass ? r_a : sat_res;
    end

    assign o_done = r_vld[3];
    assign o_res  = r_res;

endmodule

FILE: rtl/obb_separating_axis_test.sv
// top level: oriented box overlap test over the fifteen separating axes
// A load request (op 0..9) stores three signed Q16.16 components (an axis, a
// center or the half widths of box A or B) into a 45-entry operand store,
// one component a cycle, and gives no result. A run request (op 10) steps a
// small sequencer through up to 132 product terms on one shared multiplier:
// differences of centers, the 3x3 relative rotation, the translation on the
// A axes, then the tests on A0..A2, B0..B2 and the nine cross axes in that
// order. Each term passes through a store read and the four-stage multiplier
// (operand latch first), and each group ends with a step that stores or
// compares, so a run that finds no separating axis takes longest and one
// that stops early takes less. The result holds in an output register until
// taken; the block accepts no request while a load, a run or an untaken
// result is pending. Ops 11..15 are dropped.
module obb_separating_axis_test #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [3:0]         i_op,
    input  logic signed [31:0] i_x,
    input  logic signed [31:0] i_y,
    input  logic signed [31:0] i_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_overlap,
    output logic [3:0]         o_separating_axis
);
    import obb_sat_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int EW = (DW > 32 ? DW : 32) + 1;
    localparam int AW = DW + 4;

    localparam logic signed [EW-1:0] LD_MAX = EW'((65'sd1 <<< (DW - 1)) - 65'sd1);
    localparam logic signed [EW-1:0] LD_MIN = -LD_MAX - EW'(1);
    localparam logic signed [AW-1:0] AC_MAX = AW'((65'sd1 <<< (DW - 1)) - 65'sd1);
    localparam logic signed [AW-1:0] AC_MIN = -AC_MAX - AW'(1);
    localparam logic signed [DW:0]   AB_MAX = (DW+1)'((65'sd1 <<< (DW - 1)) - 65'sd1);

    // sign-extend then clamp a loaded component to the internal width
    function automatic logic signed [DW-1:0] sat_load(input logic signed [31:0] v);
        logic signed [EW-1:0] w;
        w = EW'(v);
        if (w > LD_MAX) begin
            w = LD_MAX;
        end else if (w < LD_MIN) begin
            w = LD_MIN;
        end
        return DW'(w);
    endfunction

    function automatic logic signed [DW-1:0] sat_acc(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] w;
        w = v;
        if (w > AC_MAX) begin
            w = AC_MAX;
        end else if (w < AC_MIN) begin
            w = AC_MIN;
        end
        return DW'(w);
    endfunction

    // |r| + 1 lsb, clamped: the epsilon on the absolute rotation terms
    function automatic logic signed [DW-1:0] abs_inc(input logic signed [DW-1:0] v);
        logic signed [DW:0] e;
        e = (DW+1)'(v);
        if (e < 0) begin
            e = -e;
        end
        e = e + (DW+1)'(1);
        if (e > AB_MAX) begin
            e = AB_MAX;
        end
        return DW'(e);
    endfunction

    // sequencer registers
    t_state               r_state, n_state;
    t_phase               r_phase, n_phase;
    logic [3:0]           r_grp, n_grp;
    logic [2:0]           r_term, n_term;
    logic [1:0]           r_cnt, n_cnt;
    logic [ADDR_W-1:0]    r_base, n_base;
    logic signed [AW-1:0] r_acc_d, n_acc_d;
    logic signed [AW-1:0] r_acc_r, n_acc_r;
    logic signed [DW-1:0] r_vec [3];
    logic signed [DW-1:0] n_vec [3];
    logic                 r_overlap, n_overlap;
    logic [3:0]           r_axis, n_axis;

    // store and multiplier hookup
    t_step                step;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [DW-1:0]        mem_wdata;
    logic [DW-1:0]        rd_a;
    logic [DW-1:0]        rd_b;
    logic                 mul_start;
    logic signed [DW-1:0] mul_b;
    logic                 mul_done;
    logic signed [DW-1:0] mul_res;
    logic signed [AW-1:0] term;
    logic signed [AW:0]   abs_d;

    assign step = step_decode(r_phase, r_grp, r_term);

    obb_sat_mem #(
        .DATA_WIDTH(DW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (step.a_addr),
        .i_raddr_b (step.b_addr),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    assign mul_b = step.b_abs ? abs_inc($signed(rd_b)) : $signed(rd_b);

    obb_sat_mul #(
        .DATA_WIDTH(DW),
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_pass  (step.pass),
        .i_a     ($signed(rd_a)),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    // signed product term and the magnitude of the projected distance
    assign term  = step.neg ? -AW'(mul_res) : AW'(mul_res);
    assign abs_d = (r_acc_d < 0) ? -(AW+1)'(r_acc_d) : (AW+1)'(r_acc_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_D;
            r_grp   <= '0;
            r_term  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_grp   <= n_grp;
            r_term  <= n_term;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base    <= n_base;
        r_acc_d   <= n_acc_d;
        r_acc_r   <= n_acc_r;
        r_vec     <= n_vec;
        r_overlap <= n_overlap;
        r_axis    <= n_axis;
    end

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_grp     = r_grp;
        n_term    = r_term;
        n_cnt     = r_cnt;
        n_base    = r_base;
        n_acc_d   = r_acc_d;
        n_acc_r   = r_acc_r;
        n_vec     = r_vec;
        n_overlap = r_overlap;
        n_axis    = r_axis;
        mem_we    = 1'b0;
        mem_waddr = r_base + ADDR_W'(r_cnt);
        mem_wdata = r_vec[r_cnt];
        mul_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_op <= OP_HB) begin
                        // every load lands at three times its op code
                        n_vec[0] = sat_load(i_x);
                        n_vec[1] = sat_load(i_y);
                        n_vec[2] = sat_load(i_z);
                        n_base   = ADDR_W'({i_op, 1'b0}) + ADDR_W'(i_op);
                        n_cnt    = '0;
                        n_state  = ST_LOAD;
                    end else if (i_op == OP_RUN) begin
                        n_phase = PH_D;
                        n_grp   = '0;
                        n_term  = '0;
                        n_acc_d = '0;
                        n_acc_r = '0;
                        n_state = ST_READ;
                    end
                end
            end
            ST_LOAD: begin
                mem_we = 1'b1;
                if (r_cnt == 2'd2) begin
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 2'd1;
                end
            end
            ST_READ: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                mul_start = 1'b1;
                n_state   = ST_WAIT;
            end
            ST_WAIT: begin
                if (mul_done) begin
                    if (step.to_rad) begin
                        n_acc_r = r_acc_r + term;
                    end else begin
                        n_acc_d = r_acc_d + term;
                    end
                    if (step.last) begin
                        n_state = ST_END;
                    end else begin
                        n_term  = r_term + 3'd1;
                        n_state = ST_READ;
                    end
                end
            end
            ST_END: begin
                n_acc_d = '0;
                n_acc_r = '0;
                n_term  = '0;
                if (!step.is_test) begin
                    mem_we    = 1'b1;
                    mem_waddr = step.dst;
                    mem_wdata = sat_acc(r_acc_d);
                end
                if (step.is_test && (abs_d > (AW+1)'(r_acc_r))) begin
                    // separating axis found, stop here
                    n_overlap = 1'b0;
                    n_axis    = step.axis;
                    n_state   = ST_OUT;
                end else if (r_grp == last_grp(r_phase)) begin
                    n_grp = '0;
                    if (r_phase == PH_X) begin
                        n_overlap = 1'b1;
                        n_axis    = AXIS_NONE;
                        n_state   = ST_OUT;
                    end else begin
                        n_phase = next_phase(r_phase);
                        n_state = ST_READ;
                    end
                end else begin
                    n_grp   = r_grp + 4'd1;
                    n_state = ST_READ;
                end
            end
            ST_OUT: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_ready           = (r_state == ST_IDLE);
    assign o_valid           = (r_state == ST_OUT);
    assign o_overlap         = r_overlap;
    assign o_separating_axis = r_axis;

endmodule

FILE: rtl/obb_sat_chk.sv
// port-level checks for the box overlap test, bound to the top level
module obb_sat_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic [3:0] i_op,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_overlap,
    input logic [3:0] o_separating_axis
);
    import obb_sat_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_overlap)
                                && $stable(o_separating_axis))
        else $error("stalled result changed");

    // overlap flag agrees with the axis code
    a_flag_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_overlap == (o_separating_axis == AXIS_NONE)))
        else $error("overlap flag and axis disagree");

    // no request taken while a result is pending
    a_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("request taken with result pending");

    // a run never answers in the next cycle
    a_run_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_op == OP_RUN) |=> !o_valid && !o_ready)
        else $error("run finished too early");

    // one result per run
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |=> !o_valid)
        else $error("result repeated");

endmodule

bind obb_separating_axis_test obb_sat_chk u_chk (.*);

FILE: tb/obb_separating_axis_test_test.sv
// self-checking testbench for the oriented box overlap test
`timescale 1ns / 100ps

module obb_separating_axis_test_test;
    import obb_sat_pkg::*;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [3:0] OP_AXA0 = 4'd0;
    localparam logic [3:0] OP_AXB0 = 4'd3;
    localparam logic [3:0] OP_CA   = 4'd6;
    localparam logic [3:0] OP_CB   = 4'd7;
    localparam logic [3:0] OP_HA   = 4'd8;

    typedef struct {
        logic [3:0]         op;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_request;

    typedef struct {
        logic       overlap;
        logic [3:0] axis;
    } t_verdict;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [3:0]         i_op;
    logic signed [31:0] i_x;
    logic signed [31:0] i_y;
    logic signed [31:0] i_z;
    logic               o_valid;
    logic               i_ready;
    logic               o_overlap;
    logic [3:0]         o_separating_axis;

    obb_separating_axis_test i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_op              (i_op),
        .i_x               (i_x),
        .i_y               (i_y),
        .i_z               (i_z),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_overlap         (o_overlap),
        .o_separating_axis (o_separating_axis)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // shadow copy of the operand store
    logic signed [63:0] sh_axes [18];
    logic signed [63:0] sh_ctr [6];
    logic signed [63:0] sh_hw [6];

    t_request pending_reqs[$];
    t_verdict expected_verdicts[$];
    int       fail_count;
    bit       stim_done;
    bit       hold_off;

    function automatic logic signed [63:0] sat_w(input logic signed [127:0] v);
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = (128'sd1 <<< (DW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi[63:0];
        if (v < lo) return lo[63:0];
        return v[63:0];
    endfunction

    // fixed multiply, magnitude truncated then saturated
    function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic [127:0]        ma;
        logic [127:0]        mb;
        logic [127:0]        p;
        logic signed [127:0] q;
        ma = a < 0 ? 128'(-a) : 128'(a);
        mb = b < 0 ? 128'(-b) : 128'(b);
        p = (ma * mb) >> FB;
        q = $signed(p);
        if ((a < 0) != (b < 0)) q = -q;
        return sat_w(q);
    endfunction

    function automatic logic signed [63:0] mag64(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    // first separating axis, 0 when the boxes overlap
    function automatic logic [3:0] find_separating_axis();
        logic signed [63:0] rot [3][3];
        logic signed [63:0] arot [3][3];
        logic signed [63:0] tr [3];
        logic signed [63:0] dc [3];
        logic signed [63:0] ra;
        logic signed [63:0] rb;
        logic signed [63:0] proj;
        int i1, i2, j1, j2;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                rot[i][j] = sat_w(128'(qmul(sh_axes[i*3], sh_axes[9+j*3]))
                    + qmul(sh_axes[i*3+1], sh_axes[9+j*3+1])
                    + qmul(sh_axes[i*3+2], sh_axes[9+j*3+2]));
                arot[i][j] = sat_w(128'(mag64(rot[i][j])) + 1);
            end
        end
        for (int i = 0; i < 3; i++) dc[i] = sat_w(128'(sh_ctr[3+i]) - sh_ctr[i]);
        for (int i = 0; i < 3; i++) begin
            tr[i] = sat_w(128'(qmul(dc[0], sh_axes[i*3])) + qmul(dc[1], sh_axes[i*3+1])
                + qmul(dc[2], sh_axes[i*3+2]));
        end
        for (int i = 0; i < 3; i++) begin
            rb = qmul(sh_hw[3], arot[i][0]) + qmul(sh_hw[4], arot[i][1])
                + qmul(sh_hw[5], arot[i][2]);
            if (mag64(tr[i]) > sh_hw[i] + rb) return AXIS_A0 + 4'(i);
        end
        for (int j = 0; j < 3; j++) begin
            ra = qmul(sh_hw[0], arot[0][j]) + qmul(sh_hw[1], arot[1][j])
                + qmul(sh_hw[2], arot[2][j]);
            proj = qmul(tr[0], rot[0][j]) + qmul(tr[1], rot[1][j]) + qmul(tr[2], rot[2][j]);
            if (mag64(proj) > ra + sh_hw[3+j]) return AXIS_B0 + 4'(j);
        end
        for (int i = 0; i < 3; i++) begin
            i1 = (i + 1) % 3;
            i2 = (i + 2) % 3;
            for (int j = 0; j < 3; j++) begin
                j1 = (j + 1) % 3;
                j2 = (j + 2) % 3;
                ra = qmul(sh_hw[i1], arot[i2][j]) + qmul(sh_hw[i2], arot[i1][j]);
                rb = qmul(sh_hw[3+j1], arot[i][j2]) + qmul(sh_hw[3+j2], arot[i][j1]);
                proj = qmul(tr[i2], rot[i1][j]) - qmul(tr[i1], rot[i2][j]);
                if (mag64(proj) > ra + rb) return AXIS_X0 + 4'(i*3 + j);
            end
        end
        return AXIS_NONE;
    endfunction

    // update the shadow store and queue the verdict of a run
    task automatic predict_request(input t_request r);
        t_verdict v;
        logic signed [63:0] c [3];
        c[0] = r.x;
        c[1] = r.y;
        c[2] = r.z;
        if (r.op <= 4'd5) begin
            for (int k = 0; k < 3; k++) sh_axes[r.op*3 + k] = c[k];
        end else if (r.op == OP_CA || r.op == OP_CB) begin
            for (int k = 0; k < 3; k++) sh_ctr[(r.op - OP_CA)*3 + k] = c[k];
        end else if (r.op == OP_HA || r.op == OP_HB) begin
            for (int k = 0; k < 3; k++) sh_hw[(r.op - OP_HA)*3 + k] = c[k];
        end else if (r.op == OP_RUN) begin
            v.axis = find_separating_axis();
            v.overlap = (v.axis == AXIS_NONE);
            expected_verdicts.push_back(v);
        end
    endtask

    function automatic logic signed [31:0] rand_comp(input int kind);
        case (kind)
            0: return $signed($urandom);
            1: return $signed(32'($urandom_range(0, 131072)) - 32'sd65536);
            2: return $signed(32'($urandom_range(0, 20 << 16)) - 32'sd655360);
            default: return $signed(32'($urandom_range(0, 4 << 16)));
        endcase
    endfunction

    task automatic add_req(input logic [3:0] op, input logic signed [31:0] x,
                           input logic signed [31:0] y, input logic signed [31:0] z);
        t_request r;
        r.op = op;
        r.x = x;
        r.y = y;
        r.z = z;
        pending_reqs.push_back(r);
    endtask

    // a full box pair with random content, then a run
    task automatic add_box_pair(input int kind);
        for (int op = 0; op < 10; op++) begin
            if (op >= OP_HA)
                add_req(4'(op), rand_comp(3), rand_comp(3), rand_comp(3));
            else
                add_req(4'(op), rand_comp(kind), rand_comp(kind), rand_comp(kind));
        end
        add_req(OP_RUN, rand_comp(0), rand_comp(0), rand_comp(0));
    endtask

    // stimulus
    initial begin
        int n;
        int kind;
        // unit boxes, identity axes, overlapping, then separated along y
        for (int b = 0; b < 2; b++) begin
            add_req(OP_AXA0 + 4'd0, 32'sh10000, 0, 0);
            add_req(OP_AXA0 + 4'd1, 0, 32'sh10000, 0);
            add_req(OP_AXA0 + 4'd2, 0, 0, 32'sh10000);
            add_req(OP_AXB0 + 4'd0, 32'sh10000, 0, 0);
            add_req(OP_AXB0 + 4'd1, 0, 32'sh10000, 0);
            add_req(OP_AXB0 + 4'd2, 0, 0, 32'sh10000);
        end
        add_req(OP_HA, 32'sh10000, 32'sh10000, 32'sh10000);
        add_req(OP_HB, 32'sh10000, 32'sh10000, 32'sh10000);
        add_req(OP_CA, 0, 0, 0);
        add_req(OP_CB, 32'sh8000, 0, 0);
        add_req(OP_RUN, 0, 0, 0);
        add_req(OP_CB, 0, 32'sh30000, 0);
        add_req(OP_RUN, 0, 0, 0);
        // extremes: saturating centers, negative half widths, unused ops
        add_req(OP_CA, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
        add_req(OP_CB, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
        add_req(OP_RUN, 0, 0, 0);
        add_req(OP_HA, 32'shffff0000, 32'sh80000000, 32'sh7fffffff);
        add_req(4'd11, 32'shffffffff, 32'shffffffff, 32'shffffffff);
        add_req(4'd15, 0, 0, 0);
        add_req(OP_RUN, 32'shffffffff, 32'shffffffff, 32'shffffffff);
        n = 0;
        while (n < 850) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                add_box_pair(kind % 3);
                n += 11;
            end else begin
                // noise: lone loads, unused ops and repeated runs
                add_req(4'($urandom_range(0, 15)), rand_comp(kind % 3), rand_comp(0),
                    rand_comp(1));
                n++;
            end
        end
        add_req(OP_RUN, 0, 0, 0);
    end

    // acceptance of the request now on the bus, seen at the last rising edge
    logic in_taken;
    always @(posedge i_clk) begin
        in_taken <= i_valid && o_ready;
    end

    // driver: bursts with random gaps, payload changed at the falling edge
    int burst_left;
    int gap_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!(i_valid && !in_taken)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                t_request r;
                r = pending_reqs.pop_front();
                i_op <= r.op;
                i_x <= r.x;
                i_y <= r.y;
                i_z <= r.z;
                i_valid <= 1'b1;
                predict_request(r);
                if (burst_left <= 0) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
                stim_done <= 1'b1;
            end
        end
    end

    // receiver stall pattern, with one long hold-off early in the run
    int stall_cnt;
    int hold_cnt;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_cnt <= 0;
            hold_cnt <= 0;
        end else if (hold_cnt < 4000 && expected_verdicts.size() > 0 && !hold_off) begin
            hold_cnt <= hold_cnt + 1;
            i_ready <= 1'b0;
            if (hold_cnt == 3999) hold_off <= 1'b1;
        end else begin
            stall_cnt <= stall_cnt + 1;
            i_ready <= (stall_cnt % 7 < 4) || (stall_cnt % 400 < 100);
        end
    end

    // monitor: compare each result with the oldest verdict
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_verdicts.size() == 0) begin
                $error("unexpected result: overlap %0d axis %0d", o_overlap,
                    o_separating_axis);
                fail_count++;
            end else begin
                t_verdict v;
                v = expected_verdicts.pop_front();
                if (o_overlap !== v.overlap) begin
                    $error("overlap: expected %0d actual %0d", v.overlap, o_overlap);
                    fail_count++;
                end
                if (o_separating_axis !== v.axis) begin
                    $error("separating_axis: expected %0d actual %0d", v.axis,
                        o_separating_axis);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    int idle_cycles;
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        fail_count = 0;
        stim_done = 1'b0;
        hold_off = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_op = '0;
        i_x = '0;
        i_y = '0;
        i_z = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && !i_valid && expected_verdicts.size() == 0);
        repeat (1000) @(posedge i_clk);
        if (fail_count == 0 && expected_verdicts.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
